/* design/gsbp_pkg.sv */
// gsbp_pkg: shared types, constants and codes for the gshare predictor with btb
// no dependencies; imported by every module of the block
package gsbp_pkg;

   localparam int BTB_INDEX_BITS_DEF = 10;
   localparam int HISTORY_BITS_DEF   = 8;
   localparam int ADDR_W             = 64;

   localparam logic [ADDR_W-1:0] PC_STEP = 64'd4;
   localparam logic [1:0]        CTR_MAX = 2'b11;
   localparam logic [1:0]        CTR_MIN = 2'b00;

   // mode codes of a request beat
   localparam logic MODE_PREDICT = 1'b0;
   localparam logic MODE_UPDATE  = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [ADDR_W-1:0] pc;
      logic [ADDR_W-1:0] branch_target;
      logic              was_taken;
      logic              is_conditional;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] next_pc;
      logic              predicted_taken;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] tag;
      logic              cond;
      logic [ADDR_W-1:0] dest;
   } btb_entry_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic clear_en;
      logic capture;
      logic load_rsp;
      logic do_update;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_update;
   } status_type;

endpackage

/* design/gsbp_datapath.sv */
// gsbp_datapath: btb and pattern table memories, global history, clear sweep,
// prediction and training logic; depends on gsbp_pkg
module gsbp_datapath
   import gsbp_pkg::*;
#(
   parameter int BTB_INDEX_BITS = BTB_INDEX_BITS_DEF,
   parameter int HISTORY_BITS   = HISTORY_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type status,
   output rsp_type    rsp_data
);

   localparam int BTB_DEPTH = 1 << BTB_INDEX_BITS;
   localparam int PHT_DEPTH = 1 << HISTORY_BITS;
   localparam int CLR_BITS  = (BTB_INDEX_BITS > HISTORY_BITS) ? BTB_INDEX_BITS : HISTORY_BITS;

   logic          valid_mem [BTB_DEPTH];
   btb_entry_type btb_mem   [BTB_DEPTH];
   logic [1:0]    pht_mem   [PHT_DEPTH];

   req_type                   item_ff;
   logic                      valid_rd_ff;
   btb_entry_type             btb_rd_ff;
   logic [1:0]                pht_rd_ff;
   logic [HISTORY_BITS-1:0]   pidx_ff;
   logic [HISTORY_BITS-1:0]   ghr_ff, ghr_in;
   logic [CLR_BITS-1:0]       clr_cnt_ff, clr_cnt_in;
   rsp_type                   rsp_ff;

   logic [BTB_INDEX_BITS-1:0] rd_bidx, wr_bidx;
   logic [HISTORY_BITS-1:0]   rd_pidx;
   logic                      valid_we, valid_wd;
   logic [BTB_INDEX_BITS-1:0] valid_wa;
   logic                      pht_we;
   logic [HISTORY_BITS-1:0]   pht_wa;
   logic [1:0]                pht_wd, ctr_next;
   logic                      hit, redirect;
   rsp_type                   rsp_in;

   assign rd_bidx = req_data.pc[BTB_INDEX_BITS+1:2];
   assign rd_pidx = req_data.pc[HISTORY_BITS+1:2] ^ ghr_ff;
   assign wr_bidx = item_ff.pc[BTB_INDEX_BITS+1:2];

   // saturating counter step
   always_comb begin
      if (item_ff.was_taken) begin
         ctr_next = (pht_rd_ff == CTR_MAX) ? pht_rd_ff : pht_rd_ff + 2'd1;
      end else begin
         ctr_next = (pht_rd_ff == CTR_MIN) ? pht_rd_ff : pht_rd_ff - 2'd1;
      end
   end

   // single write port per memory: clear sweep or update
   always_comb begin
      valid_we = 1'b0;
      valid_wa = wr_bidx;
      valid_wd = 1'b1;
      pht_we   = 1'b0;
      pht_wa   = pidx_ff;
      pht_wd   = ctr_next;
      ghr_in   = ghr_ff;
      if (cmd.clear_en) begin
         valid_we = 1'b1;
         valid_wa = clr_cnt_ff[BTB_INDEX_BITS-1:0];
         valid_wd = 1'b0;
         pht_we   = 1'b1;
         pht_wa   = clr_cnt_ff[HISTORY_BITS-1:0];
         pht_wd   = CTR_MIN;
      end else if (cmd.do_update) begin
         valid_we = 1'b1;
         if (item_ff.is_conditional) begin
            pht_we = 1'b1;
            ghr_in = {ghr_ff[HISTORY_BITS-2:0], item_ff.was_taken};
         end
      end
   end

   assign clr_cnt_in = cmd.clear_en ? clr_cnt_ff + 1'b1 : clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         ghr_ff     <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
         ghr_ff     <= ghr_in;
      end
   end

   // valid bit memory
   always_ff @(posedge clock) begin
      if (valid_we) begin
         valid_mem[valid_wa] <= valid_wd;
      end
      if (cmd.capture) begin
         valid_rd_ff <= valid_mem[rd_bidx];
      end
   end

   // tag, kind and target memory
   always_ff @(posedge clock) begin
      if (cmd.do_update) begin
         btb_mem[wr_bidx] <= '{tag: item_ff.pc, cond: item_ff.is_conditional,
                               dest: item_ff.branch_target};
      end
      if (cmd.capture) begin
         btb_rd_ff <= btb_mem[rd_bidx];
      end
   end

   // pattern counter memory
   always_ff @(posedge clock) begin
      if (pht_we) begin
         pht_mem[pht_wa] <= pht_wd;
      end
      if (cmd.capture) begin
         pht_rd_ff <= pht_mem[rd_pidx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
         pidx_ff <= rd_pidx;
      end
   end

   assign hit      = valid_rd_ff && (btb_rd_ff.tag == item_ff.pc);
   assign redirect = hit && (!btb_rd_ff.cond || pht_rd_ff[1]);

   always_comb begin
      rsp_in.predicted_taken = redirect;
      rsp_in.next_pc         = redirect ? btb_rd_ff.dest : item_ff.pc + PC_STEP;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data          = rsp_ff;
   assign status.clear_last = &clr_cnt_ff;
   assign status.is_update  = (item_ff.mode == MODE_UPDATE);

endmodule

/* design/gsbp_controller.sv */
// gsbp_controller: sequencing state machine and result valid register
// depends on gsbp_pkg
module gsbp_controller
   import gsbp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.is_update) begin
               cmd.do_update = 1'b1;
               state_in      = ST_IDLE;
            end else if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* design/gshare_branch_predictor_btb.sv */
// gshare_branch_predictor_btb: top level, controller plus datapath
// depends on gsbp_pkg, gsbp_controller, gsbp_datapath
//
//   channel  ports                          payload   direction
//   req      req_valid req_stall req_data   req_type  in  (predict or update beat)
//   rsp      rsp_valid rsp_stall rsp_data   rsp_type  out (one beat per predict)
//
// after reset a clearing pass zeroes the btb valid bits and the pattern counters,
// one entry a cycle over 2**max(BTB_INDEX_BITS, HISTORY_BITS) sweep addresses (1024 by
// default); req_stall stays high meanwhile
// the accept edge in the idle state issues the registered memory reads, and the exec
// state then writes the result register or the btb and pattern table
// a predict beat waits in the exec state while a previous result is still stalled
// in the output register; a new beat is accepted while a result waits there
module gshare_branch_predictor_btb
   import gsbp_pkg::*;
#(
   parameter int BTB_INDEX_BITS = BTB_INDEX_BITS_DEF,
   parameter int HISTORY_BITS   = HISTORY_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // command and status between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: clear pass, accept, execute
   gsbp_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // memories, history and prediction logic
   gsbp_datapath #(
      .BTB_INDEX_BITS (BTB_INDEX_BITS),
      .HISTORY_BITS   (HISTORY_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

/* design/gsbp_checker.sv */
// gsbp_checker: port-level assertions for the gshare predictor top level
// depends on gsbp_pkg; bound to gshare_branch_predictor_btb below
module gsbp_checker
   import gsbp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic req_acc;
   assign req_acc = req_valid && !req_stall;

   // no result beat right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   // block is busy the cycle after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> req_stall)
      else $error("second beat accepted during execute");

   // an update beat gives no result
   a_update_silent: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_data.mode == MODE_UPDATE && !rsp_valid |=> !rsp_valid)
      else $error("result beat after update");

   // a predict beat with a free output gives its result: the exec state loads the result register
   a_predict_result: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_data.mode == MODE_PREDICT && !rsp_valid |-> ##2 rsp_valid)
      else $error("missing result beat for predict");

endmodule

bind gshare_branch_predictor_btb gsbp_checker u_gsbp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
